// ===== rtl/core/mi3_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse core.
// No dependencies; imported by the front end, the divider lanes and the top level.
package mi3_pkg;

    // Status that rides along with each divider lane
    typedef struct packed {
        logic ovf;   // quotient magnitude does not fit the lane width
        logic neg;   // quotient is negative
        logic zero;  // determinant is zero
    } lane_flags_t;

    // Cofactor operand table, row-major adjugate index k = r*3 + c.
    // adj[k] = m[A]*m[B] - m[C]*m[D], negated where COF_NEG is set.
    localparam int unsigned COF_A [9] = '{4, 1, 1, 3, 0, 0, 3, 0, 0};
    localparam int unsigned COF_B [9] = '{8, 8, 5, 8, 8, 5, 7, 7, 4};
    localparam int unsigned COF_C [9] = '{5, 2, 2, 5, 2, 2, 4, 1, 1};
    localparam int unsigned COF_D [9] = '{7, 7, 4, 6, 6, 3, 6, 6, 3};
    localparam bit          COF_NEG [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                            1'b1, 1'b0, 1'b1, 1'b0};

endpackage

// ===== rtl/core/mi3_front.sv =====
// Front end: adjugate and exact determinant in five register stages.
// Depends on mi3_pkg for the cofactor operand table.
module mi3_front
    import mi3_pkg::*;
#(
    parameter int EW = 16
)
(
    input  logic                 clk,
    input  logic [4:0]           ld,
    input  logic signed [EW-1:0] m [9],
    output logic signed [2*EW:0] adj [9],
    output logic signed [3*EW:0] det
);

    localparam int PW = 2 * EW;
    localparam int AW = 2 * EW + 1;
    localparam int DW = 3 * EW + 1;

    logic signed [EW-1:0] m_s0_reg [9];
    logic signed [EW-1:0] r0_s1_reg [3];
    logic signed [EW-1:0] r0_s2_reg [3];
    logic signed [PW-1:0] pa_s1_reg [9];
    logic signed [PW-1:0] pc_s1_reg [9];
    logic signed [AW-1:0] adj_s2_reg [9];
    logic signed [AW-1:0] adj_s3_reg [9];
    logic signed [AW-1:0] adj_s4_reg [9];
    logic signed [DW-1:0] dp_s3_reg [3];
    logic signed [DW-1:0] det_s4_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            m_s0_reg <= m;
        end
        if (ld[1])
        begin
            for (int k = 0; k < 9; k++)
            begin
                pa_s1_reg[k] <= m_s0_reg[COF_A[k]] * m_s0_reg[COF_B[k]];
                pc_s1_reg[k] <= m_s0_reg[COF_C[k]] * m_s0_reg[COF_D[k]];
            end
            for (int j = 0; j < 3; j++)
            begin
                r0_s1_reg[j] <= m_s0_reg[j];
            end
        end
        if (ld[2])
        begin
            for (int k = 0; k < 9; k++)
            begin
                if (COF_NEG[k])
                    adj_s2_reg[k] <= AW'(pc_s1_reg[k]) - AW'(pa_s1_reg[k]);
                else
                    adj_s2_reg[k] <= AW'(pa_s1_reg[k]) - AW'(pc_s1_reg[k]);
            end
            r0_s2_reg <= r0_s1_reg;
        end
        if (ld[3])
        begin
            // expand along row 0: m0j times adjugate column-0 entry j
            for (int j = 0; j < 3; j++)
            begin
                dp_s3_reg[j] <= r0_s2_reg[j] * adj_s2_reg[j*3];
            end
            adj_s3_reg <= adj_s2_reg;
        end
        if (ld[4])
        begin
            det_s4_reg <= dp_s3_reg[0] + dp_s3_reg[1] + dp_s3_reg[2];
            adj_s4_reg <= adj_s3_reg;
        end
    end

    assign adj = adj_s4_reg;
    assign det = det_s4_reg;

endmodule

// ===== rtl/core/mi3_lane.sv =====
// Divider lane: one adjugate entry over the determinant, one quotient bit per stage.
// Depends on mi3_pkg for the lane status struct.
module mi3_lane
    import mi3_pkg::*;
#(
    parameter int EW = 16,
    parameter int W  = 32
)
(
    input  logic                 clk,
    input  logic [W:0]           ld,
    input  logic signed [2*EW:0] adj,
    input  logic signed [3*EW:0] det,
    output logic [W-1:0]         q_mag,
    output lane_flags_t          flags
);

    localparam int SH = (EW - 4) + W / 2;
    localparam int NW = 2 * EW + SH;
    localparam int DM = 3 * EW;
    localparam int CW = ((NW > DM + W) ? NW : DM + W) + 1;

    logic [2*EW:0] adj_abs;
    logic [3*EW:0] det_abs;
    logic [CW-1:0] n_ext;
    logic [CW-1:0] d_ext;
    lane_flags_t   flags_next;

    logic [CW-1:0] rem_reg [W];
    logic [DM-1:0] d_reg [W];
    logic [W-1:0]  q_reg [W+1];
    lane_flags_t   flags_reg [W+1];

    always_comb
    begin
        adj_abs = adj[2*EW] ? -adj : adj;
        det_abs = det[3*EW] ? -det : det;
        n_ext   = CW'(adj_abs[2*EW-1:0]) << SH;
        d_ext   = CW'(det_abs[DM-1:0]);
        flags_next.ovf  = n_ext >= (d_ext << W);
        flags_next.neg  = adj[2*EW] ^ det[3*EW];
        flags_next.zero = (det == '0);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            rem_reg[0]   <= n_ext;
            d_reg[0]     <= det_abs[DM-1:0];
            q_reg[0]     <= '0;
            flags_reg[0] <= flags_next;
        end
    end

    for (genvar j = 0; j < W; j++)
    begin : g_bit
        localparam int BIT = W - 1 - j;
        logic [CW-1:0] sub;
        logic          ge;

        assign sub = CW'(d_reg[j]) << BIT;
        assign ge  = rem_reg[j] >= sub;

        always_ff @(posedge clk)
        begin
            if (ld[j+1])
            begin
                q_reg[j+1]     <= {q_reg[j][W-2:0], ge};
                flags_reg[j+1] <= flags_reg[j];
            end
        end

        if (j < W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (ld[j+1])
                begin
                    rem_reg[j+1] <= ge ? rem_reg[j] - sub : rem_reg[j];
                    d_reg[j+1]   <= d_reg[j];
                end
            end
        end
    end

    assign q_mag = q_reg[W];
    assign flags = flags_reg[W];

endmodule

// ===== rtl/core/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse, top level: front end, nine divider lanes, merge and output stage.
// Depends on mi3_pkg, mi3_front and mi3_lane.
//
// Takes one 3x3 matrix of signed fixed-point entries (Q4.12 at the default width) per
// beat and returns one beat holding the exact determinant (scale 2^-36), the inverse
// as adjugate over determinant in signed Q16.16 (truncated toward zero, clipped to
// INV_WIDTH bits with the saturated flag), and a singular flag that comes with an
// all-zero inverse. A new matrix is accepted every clock while in_stall is low. The
// divider lanes settle one quotient bit per stage, and nine of them run side by side,
// one per inverse entry; the output stage merges their clip flags. Every stage holds
// its own valid bit and advances into a free slot, so while out_stall is high the
// pipeline keeps filling its empty stages and in_stall rises only once every stage,
// the output stage included, holds a beat.
module matrix_inverse_3x3
    import mi3_pkg::*;
#(
    parameter int ENTRY_WIDTH = 16,
    parameter int INV_WIDTH   = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [ENTRY_WIDTH-1:0] m00,
    input  logic signed [ENTRY_WIDTH-1:0] m01,
    input  logic signed [ENTRY_WIDTH-1:0] m02,
    input  logic signed [ENTRY_WIDTH-1:0] m10,
    input  logic signed [ENTRY_WIDTH-1:0] m11,
    input  logic signed [ENTRY_WIDTH-1:0] m12,
    input  logic signed [ENTRY_WIDTH-1:0] m20,
    input  logic signed [ENTRY_WIDTH-1:0] m21,
    input  logic signed [ENTRY_WIDTH-1:0] m22,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [INV_WIDTH-1:0]   inv00,
    output logic signed [INV_WIDTH-1:0]   inv01,
    output logic signed [INV_WIDTH-1:0]   inv02,
    output logic signed [INV_WIDTH-1:0]   inv10,
    output logic signed [INV_WIDTH-1:0]   inv11,
    output logic signed [INV_WIDTH-1:0]   inv12,
    output logic signed [INV_WIDTH-1:0]   inv20,
    output logic signed [INV_WIDTH-1:0]   inv21,
    output logic signed [INV_WIDTH-1:0]   inv22,
    output logic signed [3*ENTRY_WIDTH:0] determinant,
    output logic                          singular,
    output logic                          saturated
);

    localparam int EW = ENTRY_WIDTH;
    localparam int W  = INV_WIDTH;
    localparam int DW = 3 * EW + 1;
    // 5 front stages, W+1 lane stages, 1 output stage
    localparam int NS = W + 7;
    localparam int LS = 5;

    localparam logic [W-1:0] INV_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] INV_LO = {1'b1, {(W-1){1'b0}}};

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS:0]   rdy;

    logic signed [EW-1:0]  m_in [9];
    logic signed [2*EW:0]  adj_f [9];
    logic signed [DW-1:0]  det_f;
    logic [W-1:0]          q_mag [9];
    lane_flags_t           lflags [9];

    logic signed [DW-1:0]  det_pipe_reg [W+1];

    logic [W-1:0]          inv_next [9];
    logic [8:0]            sat_vec;
    logic [W-1:0]          inv_reg [9];
    logic signed [DW-1:0]  det_reg;
    logic                  sing_reg;
    logic                  sat_reg;

    // Ready ripples back from the output: a stage takes a beat when it is empty
    // or when its own beat moves on in the same cycle.
    assign rdy[NS] = !out_stall;
    for (genvar k = 0; k < NS; k++)
    begin : g_rdy
        assign rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
            vld_next[0] = in_valid;
        for (int k = 1; k < NS; k++)
        begin
            if (rdy[k])
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NS-1];

    assign m_in[0] = m00;
    assign m_in[1] = m01;
    assign m_in[2] = m02;
    assign m_in[3] = m10;
    assign m_in[4] = m11;
    assign m_in[5] = m12;
    assign m_in[6] = m20;
    assign m_in[7] = m21;
    assign m_in[8] = m22;

    mi3_front #(
        .EW (EW)
    ) u_front (
        .clk (clk),
        .ld  (rdy[LS-1:0]),
        .m   (m_in),
        .adj (adj_f),
        .det (det_f)
    );

    // One divider lane per inverse entry
    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        mi3_lane #(
            .EW (EW),
            .W  (W)
        ) u_lane (
            .clk   (clk),
            .ld    (rdy[LS+W:LS]),
            .adj   (adj_f[k]),
            .det   (det_f),
            .q_mag (q_mag[k]),
            .flags (lflags[k])
        );
    end

    // Carry the determinant alongside the lanes
    always_ff @(posedge clk)
    begin
        if (rdy[LS])
            det_pipe_reg[0] <= det_f;
        for (int j = 1; j <= W; j++)
        begin
            if (rdy[LS+j])
                det_pipe_reg[j] <= det_pipe_reg[j-1];
        end
    end

    // Merge: apply sign, clip to range, drop everything on a zero determinant
    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            inv_next[k] = '0;
            sat_vec[k]  = 1'b0;
            if (!lflags[k].zero)
            begin
                if (!lflags[k].neg)
                begin
                    if (lflags[k].ovf || q_mag[k][W-1])
                    begin
                        inv_next[k] = INV_HI;
                        sat_vec[k]  = 1'b1;
                    end
                    else
                    begin
                        inv_next[k] = q_mag[k];
                    end
                end
                else
                begin
                    if (lflags[k].ovf || (q_mag[k][W-1] && |q_mag[k][W-2:0]))
                    begin
                        inv_next[k] = INV_LO;
                        sat_vec[k]  = 1'b1;
                    end
                    else
                    begin
                        inv_next[k] = -q_mag[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[NS-1])
        begin
            inv_reg  <= inv_next;
            det_reg  <= det_pipe_reg[W];
            sing_reg <= (det_pipe_reg[W] == '0);
            sat_reg  <= |sat_vec;
        end
    end

    assign inv00       = inv_reg[0];
    assign inv01       = inv_reg[1];
    assign inv02       = inv_reg[2];
    assign inv10       = inv_reg[3];
    assign inv11       = inv_reg[4];
    assign inv12       = inv_reg[5];
    assign inv20       = inv_reg[6];
    assign inv21       = inv_reg[7];
    assign inv22       = inv_reg[8];
    assign determinant = det_reg;
    assign singular    = sing_reg;
    assign saturated   = sat_reg;

endmodule

// ===== rtl/core/mi3_check.sv =====
// Port-level checker for matrix_inverse_3x3, attached by the bind below.
// Depends only on the top level's port list.
module mi3_check #(
    parameter int ENTRY_WIDTH = 16,
    parameter int INV_WIDTH   = 32
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic signed [ENTRY_WIDTH-1:0] m00,
    input logic signed [ENTRY_WIDTH-1:0] m01,
    input logic signed [ENTRY_WIDTH-1:0] m02,
    input logic signed [ENTRY_WIDTH-1:0] m10,
    input logic signed [ENTRY_WIDTH-1:0] m11,
    input logic signed [ENTRY_WIDTH-1:0] m12,
    input logic signed [ENTRY_WIDTH-1:0] m20,
    input logic signed [ENTRY_WIDTH-1:0] m21,
    input logic signed [ENTRY_WIDTH-1:0] m22,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [INV_WIDTH-1:0]   inv00,
    input logic signed [INV_WIDTH-1:0]   inv01,
    input logic signed [INV_WIDTH-1:0]   inv02,
    input logic signed [INV_WIDTH-1:0]   inv10,
    input logic signed [INV_WIDTH-1:0]   inv11,
    input logic signed [INV_WIDTH-1:0]   inv12,
    input logic signed [INV_WIDTH-1:0]   inv20,
    input logic signed [INV_WIDTH-1:0]   inv21,
    input logic signed [INV_WIDTH-1:0]   inv22,
    input logic signed [3*ENTRY_WIDTH:0] determinant,
    input logic                          singular,
    input logic                          saturated
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(determinant) && $stable(inv00)
            && $stable(inv11) && $stable(inv22) && $stable(saturated))
        else $error("stalled result beat changed");

    a_singular_det: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (singular == (determinant == '0)))
        else $error("singular flag disagrees with determinant");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !saturated && inv00 == '0 && inv01 == '0
            && inv02 == '0 && inv10 == '0 && inv11 == '0 && inv12 == '0
            && inv20 == '0 && inv21 == '0 && inv22 == '0)
        else $error("singular beat carries a nonzero inverse");

endmodule

bind matrix_inverse_3x3 mi3_check #(
    .ENTRY_WIDTH (ENTRY_WIDTH),
    .INV_WIDTH   (INV_WIDTH)
) u_mi3_check (.*);

// ===== test/matrix_inverse_3x3_chk.sv =====
// Checker for matrix_inverse_3x3: watches both channels, predicts the inverse beat by beat.
// Depends on the block's port widths only (ENTRY_WIDTH 16, INV_WIDTH 32).
module matrix_inverse_3x3_chk
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
    input  logic signed [48:0] determinant,
    input  logic               singular,
    input  logic               saturated,
    output int                 errors,
    output int                 pending,
    output int                 n_checked,
    output int                 n_singular,
    output int                 n_saturated
);

    typedef struct packed {
        logic [8:0][31:0] inv;
        logic [48:0]      det;
        logic             sing;
        logic             sat;
    } inverse_t;

    inverse_t inverse_q [$];

    function automatic inverse_t invert_matrix(input logic [8:0][15:0] mat);
        longint   e [9];
        longint   a [9];
        longint   d;
        longint   q;
        longint   hi;
        longint   lo;
        inverse_t r;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        for (int k = 0; k < 9; k++)
            e[k] = longint'($signed(mat[k]));
        a[0] =   e[4] * e[8] - e[5] * e[7];
        a[3] = -(e[3] * e[8] - e[5] * e[6]);
        a[6] =   e[3] * e[7] - e[4] * e[6];
        a[1] = -(e[1] * e[8] - e[2] * e[7]);
        a[4] =   e[0] * e[8] - e[2] * e[6];
        a[7] = -(e[0] * e[7] - e[1] * e[6]);
        a[2] =   e[1] * e[5] - e[2] * e[4];
        a[5] = -(e[0] * e[5] - e[2] * e[3]);
        a[8] =   e[0] * e[4] - e[1] * e[3];
        d = e[0] * a[0] + e[1] * a[3] + e[2] * a[6];
        r.sat = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            q = 0;
            if (d != 0)
            begin
                // Q8.24 adjugate over Q12.36 det -> Q16.16: scale by 2^28, truncate
                q = (a[k] * (64'sd1 <<< 28)) / d;
                if (q > hi) begin q = hi; r.sat = 1'b1; end
                if (q < lo) begin q = lo; r.sat = 1'b1; end
            end
            r.inv[k] = q[31:0];
        end
        r.det  = d[48:0];
        r.sing = (d == 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        inverse_t         exp_r;
        logic [8:0][31:0] got;
        int               errs;
        if (!rst_n)
        begin
            inverse_q.delete();
            errors      <= 0;
            pending     <= 0;
            n_checked   <= 0;
            n_singular  <= 0;
            n_saturated <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && !in_stall)
                inverse_q.push_back(invert_matrix({m22, m21, m20, m12, m11, m10, m02, m01, m00}));
            if (out_valid && !out_stall)
            begin
                if (inverse_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, det %0d", $time,
                             determinant);
                    errs++;
                end
                else
                begin
                    exp_r = inverse_q.pop_front();
                    got = {inv22, inv21, inv20, inv12, inv11, inv10, inv02, inv01, inv00};
                    n_checked   <= n_checked + 1;
                    n_singular  <= n_singular + exp_r.sing;
                    n_saturated <= n_saturated + exp_r.sat;
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== exp_r.inv[k])
                        begin
                            $display("%0t: inv%0d%0d expected %0d actual %0d", $time, k / 3,
                                     k % 3, $signed(exp_r.inv[k]), $signed(got[k]));
                            errs++;
                        end
                    if (determinant !== exp_r.det)
                    begin
                        $display("%0t: determinant expected %0d actual %0d", $time,
                                 $signed(exp_r.det), determinant);
                        errs++;
                    end
                    if (singular !== exp_r.sing)
                    begin
                        $display("%0t: singular expected %0b actual %0b", $time,
                                 exp_r.sing, singular);
                        errs++;
                    end
                    if (saturated !== exp_r.sat)
                    begin
                        $display("%0t: saturated expected %0b actual %0b", $time,
                                 exp_r.sat, saturated);
                        errs++;
                    end
                end
            end
            errors  <= errors + errs;
            pending <= inverse_q.size();
        end
    end

endmodule

// ===== test/matrix_inverse_3x3_tb.sv =====
// Testbench top for matrix_inverse_3x3: clock, reset, matrix stimulus, output stall, verdict.
// Depends on matrix_inverse_3x3 (rtl) and matrix_inverse_3x3_chk.
module matrix_inverse_3x3_tb;

    localparam int RANDOM_ITEMS = 500;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] m [9];
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] inv [9];
    logic signed [48:0] determinant;
    logic               singular;
    logic               saturated;
    int                 errors, pending, n_checked, n_singular, n_saturated;
    int                 n_sent;
    // when set, both sides run back to back with no gaps
    logic               no_idle;

    matrix_inverse_3x3 u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
        .m20(m[6]), .m21(m[7]), .m22(m[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]), .inv10(inv[3]), .inv11(inv[4]),
        .inv12(inv[5]), .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
        .determinant(determinant), .singular(singular), .saturated(saturated)
    );

    matrix_inverse_3x3_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .m00(m[0]), .m01(m[1]), .m02(m[2]), .m10(m[3]), .m11(m[4]), .m12(m[5]),
        .m20(m[6]), .m21(m[7]), .m22(m[8]),
        .out_valid(out_valid), .out_stall(out_stall),
        .inv00(inv[0]), .inv01(inv[1]), .inv02(inv[2]), .inv10(inv[3]), .inv11(inv[4]),
        .inv12(inv[5]), .inv20(inv[6]), .inv21(inv[7]), .inv22(inv[8]),
        .determinant(determinant), .singular(singular), .saturated(saturated),
        .errors(errors), .pending(pending), .n_checked(n_checked),
        .n_singular(n_singular), .n_saturated(n_saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run (every beat with a full gap and stall).
    initial
    begin
        #5000000;
        $display("timeout with %0d results outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    // Present one matrix and hold it until the block takes the beat, then idle a while.
    // in_stall only moves on rising edges, so look at it on the falling edge.
    task automatic send_matrix(input logic signed [15:0] v [9]);
        int gap;
        in_valid <= 1'b1;
        for (int k = 0; k < 9; k++)
            m[k] <= v[k];
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        n_sent++;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return 16'sd1;
            4: return -16'sd1;
            5: return 16'sd4096;
            default: return -16'sd4096;
        endcase
    endfunction

    // Receiver: stall for a drawn number of cycles, then take one beat.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 19);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            forever
            begin
                @(negedge clk);
                if (out_valid)
                    break;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        logic signed [15:0] v [9];
        int                 kind;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        no_idle  = 1'b0;
        n_sent   = 0;
        for (int k = 0; k < 9; k++)
            m[k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: identity, zero, extremes, rank-deficient, clipping, sign of truncation.
        v = '{16'sd4096, 0, 0, 0, 16'sd4096, 0, 0, 0, 16'sd4096};
        send_matrix(v);
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(v);
        for (int k = 0; k < 9; k++) v[k] = -16'sd32768;
        send_matrix(v);
        for (int k = 0; k < 9; k++) v[k] = 16'sd32767;
        send_matrix(v);
        // most negative on the diagonal only: exact det of -2^45
        v = '{-16'sd32768, 0, 0, 0, -16'sd32768, 0, 0, 0, -16'sd32768};
        send_matrix(v);
        // tiniest entries: inverse of 4096 on the diagonal, still in range
        v = '{16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
        send_matrix(v);
        v = '{-16'sd1, 0, 0, 0, 16'sd1, 0, 0, 0, 16'sd1};
        send_matrix(v);
        // upper 2x2 with determinant -1: huge cofactor ratio, clips both ways
        v = '{16'sd32767, 16'sd32766, 0, 16'sd32766, 16'sd32765, 0, 0, 0, 16'sd4096};
        send_matrix(v);
        // two equal rows
        v = '{16'sd100, -16'sd200, 16'sd300, 16'sd100, -16'sd200, 16'sd300, 16'sd7, 16'sd8, 16'sd9};
        send_matrix(v);
        // one zero column
        v = '{16'sd5, 0, 16'sd3, -16'sd9, 0, 16'sd2, 16'sd4, 0, -16'sd1};
        send_matrix(v);
        // non-exact quotients of both signs
        v = '{16'sd3, 16'sd1, 0, 16'sd1, -16'sd3, 16'sd1, 0, 16'sd1, 16'sd7};
        send_matrix(v);
        v = '{16'sd4096, 16'sd2048, 16'sd1024, -16'sd2048, 16'sd12288, 16'sd4096,
              16'sd1024, -16'sd4096, 16'sd8192};
        send_matrix(v);
        // alternating bit patterns
        v = '{16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555, 16'sh2aaa,
              16'sh2aaa, 16'sh5555, -16'sh5556};
        send_matrix(v);

        // Random: raw entries, small entries, extreme values, near-singular and exactly singular sets.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // a back-to-back stretch every so often
            no_idle = ((i % 100) >= 80);
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 9; k++)
                v[k] = 16'($urandom());
            case (kind)
                4, 5:
                    for (int k = 0; k < 9; k++)
                        v[k] = (k % 4 == 0 ? 16'sd4096 : 16'sd0)
                               + $signed(16'($urandom_range(0, 1023))) - 16'sd512;
                6:
                    for (int k = 0; k < 3; k++)
                        v[6 + k] = v[k];
                7:
                    for (int k = 0; k < 3; k++)
                    begin
                        v[k]     = v[k] >>> 1;
                        v[3 + k] = v[3 + k] >>> 1;
                        v[6 + k] = v[k] + v[3 + k];
                    end
                8:
                    for (int k = 0; k < 3; k++)
                    begin
                        v[k]     = v[k] >>> 1;
                        v[3 + k] = v[k] + $signed(16'($urandom_range(0, 4))) - 16'sd2;
                    end
                9:
                    for (int k = 0; k < 9; k++)
                        v[k] = pick_extreme();
                default: ;
            endcase
            send_matrix(v);
        end
        in_valid <= 1'b0;
        no_idle  = 1'b0;

        // drain, then let the pipeline settle so stray beats get caught
        forever
        begin
            @(negedge clk);
            if (pending == 0)
                break;
        end
        repeat (60) @(posedge clk);

        $display("sent %0d matrices, checked %0d results", n_sent, n_checked);
        $display("singular results %0d, clipped results %0d", n_singular, n_saturated);
        if (errors == 0 && n_checked == n_sent)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
